FILE: rtl/k3m_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// k3m_pkg
// Shared constants and set-membership function for the thinning block.
// ---------------------------------------------------------------------------
package k3m_pkg;

  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_RUN   = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  localparam logic [0:0] REG_COLS = 1'd0;
  localparam logic [0:0] REG_ROWS = 1'd1;

  // run-length ranges of sets A0 .. A5
  localparam logic [2:0] RUN_MIN [6] = '{3'd2, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3};
  localparam logic [2:0] RUN_MAX [6] = '{3'd7, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7};

  // true when the set bits of w form one circular run of length lo..hi
  function automatic logic in_set(input logic [7:0] w, input logic [2:0] set);
    logic       hit;
    logic [7:0] pat;
    logic [3:0] len;
    hit = 1'b0;
    for (int j = 0; j < 8; j++) begin
      pat = 8'd0;
      for (int k = 0; k < 7; k++) begin
        pat[(j + k) % 8] = 1'b1;
        len = 4'(k + 1);
        if (len >= {1'b0, RUN_MIN[set]} && len <= {1'b0, RUN_MAX[set]} && pat == w)
          hit = 1'b1;
      end
    end
    return hit;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/k3m_ram.sv
`default_nettype none
// ---------------------------------------------------------------------------
// k3m_ram
// Generic single-port synchronous RAM with registered read.
// ---------------------------------------------------------------------------
module k3m_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 65536
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire  [$clog2(DEPTH)-1:0] addr,
  input  wire  [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

FILE: rtl/k3m_binary_thinning.sv
`default_nettype none
// Write, read and unused requests pass through the read and response states
// before done, and a new request is taken only back in idle. A run sweeps every
// interior pixel 7 times per pass (mark, five phases, clear) plus one final
// sweep; each visit takes 10 window fetch steps, a mark read, evaluate, advance.
// A run ends through the finish and response states; busy is high until then
// and the receiver cannot stall. Sync reset: stores kept, registers 256, counter 0.
// ---------------------------------------------------------------------------
// k3m_binary_thinning
// K3M thinning engine over a one-bit frame store and a one-bit mark store.
// ---------------------------------------------------------------------------
module k3m_binary_thinning #(
  parameter int MAX_COLS = 256,
  parameter int MAX_ROWS = 256
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        start,
  output logic       busy,
  input  wire  [1:0] kind,
  input  wire  [7:0] row_index,
  input  wire  [7:0] col_index,
  input  wire        pixel_in,
  output logic       done,
  output logic       pixel_out,
  output logic [15:0] pass_count,
  input  wire        cfg_valid,
  output logic       cfg_ready,
  input  wire        cfg_index,
  input  wire  [8:0] cfg_data
);
  import k3m_pkg::*;

  localparam int CW = $clog2(MAX_COLS);
  localparam int RW = $clog2(MAX_ROWS);
  localparam int AW = CW + RW;
  localparam int DEPTH = 2 ** AW;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_ACC   = 8'b00000010,
    S_READ  = 8'b00000100,
    S_NB    = 8'b00001000,
    S_EVAL  = 8'b00010000,
    S_NEXT  = 8'b00100000,
    S_FIN   = 8'b01000000,
    S_RESP  = 8'b10000000
  } state_t;

  state_t      state;
  logic [8:0]  cols_in_use, rows_in_use;
  logic [12:0] cols_eff, rows_eff;
  logic [RW-1:0] r;
  logic [CW-1:0] c;
  logic [2:0]  ph;       // 0 mark, 1..5 delete, 6 clear marks, 7 final
  logic [3:0]  nb;       // neighbor fetch step
  logic [7:0]  w;
  logic        ctr;
  logic        mark;
  logic        again;
  logic        req_read, req_in;
  logic [15:0] passes_done;

  logic          f_we, m_we, f_wd, m_wd, f_rd, m_rd;
  logic [AW-1:0] f_addr, m_addr, cur_addr;
  logic [RW-1:0] nr;
  logic [CW-1:0] nc;
  logic [1:0]    dj, dk;
  logic [7:0]    code;
  logic [7:0]    code_prev;

  k3m_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_frame (
    .clk(clk), .we(f_we), .addr(f_addr), .wdata(f_wd), .rdata(f_rd));
  k3m_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_mark (
    .clk(clk), .we(m_we), .addr(m_addr), .wdata(m_wd), .rdata(m_rd));

  assign cols_eff = ({4'd0, cols_in_use} > 13'(MAX_COLS)) ? 13'(MAX_COLS)
                                                          : {4'd0, cols_in_use};
  assign rows_eff = ({4'd0, rows_in_use} > 13'(MAX_ROWS)) ? 13'(MAX_ROWS)
                                                          : {4'd0, rows_in_use};
  assign cur_addr = {r, c};
  assign cfg_ready = (state == S_IDLE);
  assign busy = (state != S_IDLE);

  // nb 0..8 walks the 3x3 window in raster order
  always_comb begin
    case (nb)
      4'd0: begin dj = 2'd0; dk = 2'd0; code = 8'd128; end
      4'd1: begin dj = 2'd0; dk = 2'd1; code = 8'd1; end
      4'd2: begin dj = 2'd0; dk = 2'd2; code = 8'd2; end
      4'd3: begin dj = 2'd1; dk = 2'd0; code = 8'd64; end
      4'd4: begin dj = 2'd1; dk = 2'd1; code = 8'd0; end
      4'd5: begin dj = 2'd1; dk = 2'd2; code = 8'd4; end
      4'd6: begin dj = 2'd2; dk = 2'd0; code = 8'd32; end
      4'd7: begin dj = 2'd2; dk = 2'd1; code = 8'd16; end
      4'd8: begin dj = 2'd2; dk = 2'd2; code = 8'd8; end
      default: begin dj = 2'd0; dk = 2'd0; code = 8'd0; end
    endcase
    nr = r + RW'(dj) - RW'(1);
    nc = c + CW'(dk) - CW'(1);
  end

  logic del;
  always_comb begin
    f_we = 1'b0; f_wd = 1'b0; m_we = 1'b0; m_wd = 1'b0;
    f_addr = cur_addr; m_addr = cur_addr;
    del = 1'b0;
    case (state)
      S_IDLE: begin
        f_addr = {RW'(row_index), CW'(col_index)};
        f_we = start && kind == KIND_WRITE && req_in;
        f_wd = pixel_in;
      end
      S_NB: begin
        f_addr = {nr, nc};
      end
      S_EVAL: begin
        case (ph)
          3'd0: begin
            m_we = 1'b1;
            m_wd = ctr && in_set(w, 3'd0);
          end
          3'd6: begin
            m_we = 1'b1;
            m_wd = 1'b0;
          end
          3'd7: begin
            f_we = ctr && in_set(w, 3'd0);
            f_wd = 1'b0;
          end
          default: begin
            del = mark && in_set(w, ph);
            f_we = del; m_we = del;
          end
        endcase
      end
      default: ;
    endcase
  end

  // address range check for requests
  always_comb begin
    req_in = (32'(row_index) < MAX_ROWS) && (32'(col_index) < MAX_COLS);
  end

  logic last_c, last_r;
  assign last_c = (13'(c) + 13'd2 >= cols_eff);
  assign last_r = (13'(r) + 13'd2 >= rows_eff);

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      cols_in_use <= 9'd256;
      rows_in_use <= 9'd256;
      passes_done <= 16'd0;
      pixel_out <= 1'b0;
      pass_count <= 16'd0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cfg_valid) begin
            if (cfg_index == REG_COLS) cols_in_use <= cfg_data;
            else rows_in_use <= cfg_data;
          end
          if (start) begin
            req_read <= (kind == KIND_READ) && req_in;
            if (kind == KIND_RUN) begin
              passes_done <= 16'd1;
              again <= 1'b0;
              ph <= 3'd0;
              r <= RW'(1); c <= CW'(1);
              if (cols_eff < 13'd3 || rows_eff < 13'd3) state <= S_FIN;
              else begin
                nb <= 4'd0; w <= 8'd0; state <= S_NB;
              end
            end else state <= S_READ;
          end
        end
        S_READ: begin
          pixel_out <= req_read & f_rd;
          state <= S_RESP;
        end
        S_RESP: begin
          done <= 1'b1;
          pass_count <= passes_done;
          state <= S_IDLE;
        end
        S_NB: begin
          // rdata of previous address lands here
          if (nb != 4'd0) begin
            if (nb == 4'd5) ctr <= f_rd;
            else if (f_rd) w <= w | code_prev;
          end
          nb <= nb + 4'd1;
          if (nb == 4'd9) state <= S_ACC;
        end
        S_ACC: begin
          mark <= m_rd;
          state <= S_EVAL;
        end
        S_EVAL: begin
          if (ph == 3'd5 && del) again <= 1'b1;
          state <= S_NEXT;
        end
        S_NEXT: begin
          nb <= 4'd0; w <= 8'd0;
          state <= S_NB;
          if (!last_c) c <= c + CW'(1);
          else begin
            c <= CW'(1);
            if (!last_r) r <= r + RW'(1);
            else begin
              r <= RW'(1);
              if (ph == 3'd7) state <= S_FIN;
              else if (ph == 3'd6) begin
                if (again) begin
                  again <= 1'b0;
                  ph <= 3'd0;
                  if (passes_done != 16'hFFFF) passes_done <= passes_done + 16'd1;
                end else ph <= 3'd7;
              end else ph <= ph + 3'd1;
            end
          end
        end
        S_FIN: begin
          req_read <= 1'b0;
          pixel_out <= 1'b0;
          state <= S_RESP;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // code of the neighbor whose read data arrives this cycle
  always_ff @(posedge clk) begin
    code_prev <= code;
  end

`ifndef SYNTH
  a_done_one: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done held two cycles");
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("request not taken");
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("result without request");
  a_pass_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_EVAL) |-> passes_done != 16'd0) else $error("pass count zero in run");
`endif
endmodule
`default_nettype wire
